[hw/rtl/psc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the postfix stack calculator.
// Used by psc_front, psc_arith, psc_back and the top level; depends on nothing.
package psc_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    localparam int CMD_W       = 3;
    localparam int OPERAND_W   = 32;
    localparam int TOP_W       = 32;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Depth of the token queue between front and back.
    localparam int Q_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    typedef enum logic [2:0] {
        OK_PUSH,
        OK_ADD,
        OK_SUB,
        OK_MUL,
        OK_DIV,
        OK_NOP
    } op_kind_t;

    typedef enum logic {
        AU_MUL,
        AU_DIV
    } au_op_t;

    typedef enum logic [1:0] {
        BK_READY,
        BK_WAIT,
        BK_FILL,
        BK_RESP
    } bk_state_t;

    // Head of the token queue as seen by the back end.
    typedef struct packed {
        logic     valid;
        op_kind_t kind;
    } q_head_t;

endpackage

[hw/rtl/psc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts tokens, classifies the command and queues them for the back end.
// Depends on psc_pkg.
module psc_front #(
    parameter int DATA_WIDTH = psc_pkg::DEF_DATA_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psc_pkg::CMD_W-1:0]      cmd,
    input  logic [psc_pkg::OPERAND_W-1:0]  operand,
    input  logic                           q_pop,
    output psc_pkg::q_head_t               q_head,
    output logic [DATA_WIDTH-1:0]          q_value
);

    localparam int QAW = $clog2(psc_pkg::Q_DEPTH);
    localparam int QCW = $clog2(psc_pkg::Q_DEPTH + 1);

    psc_pkg::op_kind_t     kind_q   [psc_pkg::Q_DEPTH];
    logic [DATA_WIDTH-1:0] value_q  [psc_pkg::Q_DEPTH];
    logic [QAW-1:0]        wr_ptr_reg;
    logic [QAW-1:0]        rd_ptr_reg;
    logic [QCW-1:0]        count_reg;
    psc_pkg::op_kind_t     kind_in;
    logic [DATA_WIDTH-1:0] value_in;
    logic                  do_push;
    logic                  do_pop;

    always_comb begin
        unique case (cmd)
            psc_pkg::CMD_PUSH: kind_in = psc_pkg::OK_PUSH;
            psc_pkg::CMD_ADD:  kind_in = psc_pkg::OK_ADD;
            psc_pkg::CMD_SUB:  kind_in = psc_pkg::OK_SUB;
            psc_pkg::CMD_MUL:  kind_in = psc_pkg::OK_MUL;
            psc_pkg::CMD_DIV:  kind_in = psc_pkg::OK_DIV;
            default:           kind_in = psc_pkg::OK_NOP;
        endcase
    end

    // The operand arrives as 32-bit two's complement and is fitted to the stack width.
    assign value_in = DATA_WIDTH'(signed'(operand));

    assign s_tready = (count_reg != QCW'(psc_pkg::Q_DEPTH));
    assign do_push  = s_tvalid && s_tready;
    assign do_pop   = q_pop && (count_reg != '0);

    assign q_head.valid = (count_reg != '0);
    assign q_head.kind  = kind_q[rd_ptr_reg];
    assign q_value      = value_q[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(psc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(psc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            kind_q[wr_ptr_reg]  <= kind_in;
            value_q[wr_ptr_reg] <= value_in;
        end
    end

endmodule

[hw/rtl/psc_arith.sv]
`timescale 1ns / 1ps
// Iterative arithmetic unit: shift-and-add multiply and restoring signed divide,
// one bit per cycle. Depends on psc_pkg.
module psc_arith #(
    parameter int DATA_WIDTH = psc_pkg::DEF_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  psc_pkg::au_op_t       op,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int CNTW = $clog2(DATA_WIDTH);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNTW-1:0]       cnt_reg;
    psc_pkg::au_op_t       op_reg;
    logic                  neg_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   trial;
    logic                  rem_ge;
    logic                  a_neg;
    logic                  b_neg;

    assign a_neg     = a[DATA_WIDTH-1];
    assign b_neg     = b[DATA_WIDTH-1];
    // For a divide, a_reg shifts the dividend out at the top and the quotient in at the bottom.
    assign rem_shift = {rem_reg, a_reg[DATA_WIDTH-1]};
    assign trial     = rem_shift - {1'b0, b_reg};
    assign rem_ge    = (rem_shift >= {1'b0, b_reg});

    assign done   = done_reg;
    assign result = (op_reg == psc_pkg::AU_DIV) ? (neg_reg ? ('0 - a_reg) : a_reg) : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(DATA_WIDTH - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg  <= op;
            rem_reg <= '0;
            neg_reg <= a_neg ^ b_neg;
            if (op == psc_pkg::AU_DIV) begin
                a_reg <= a_neg ? ('0 - a) : a;
                b_reg <= b_neg ? ('0 - b) : b;
            end else begin
                a_reg <= a;
                b_reg <= b;
            end
        end else if (busy_reg) begin
            if (op_reg == psc_pkg::AU_DIV) begin
                rem_reg <= rem_ge ? trial[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
                a_reg   <= {a_reg[DATA_WIDTH-2:0], rem_ge};
            end else begin
                rem_reg <= rem_reg + (b_reg[0] ? a_reg : '0);
                a_reg   <= a_reg << 1;
                b_reg   <= b_reg >> 1;
            end
        end
    end

endmodule

[hw/rtl/psc_back.sv]
`timescale 1ns / 1ps
// Back end: executes queued tokens on the operand stack and holds the result register.
// Depends on psc_pkg and psc_arith.
module psc_back #(
    parameter int STACK_DEPTH = psc_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = psc_pkg::DEF_DATA_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psc_pkg::q_head_t              q_head,
    input  logic [DATA_WIDTH-1:0]         q_value,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psc_pkg::TOP_W-1:0]     top_value,
    output logic [psc_pkg::COUNT_W-1:0]   stack_count,
    output logic [psc_pkg::STATUS_W-1:0]  status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // The two top entries live in registers; the memory holds everything below them.
    logic [DATA_WIDTH-1:0]       mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0]       rd_data_reg;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic                        mem_we;

    psc_pkg::bk_state_t          state_reg;
    psc_pkg::bk_state_t          state_next;
    logic [CW-1:0]               sp_reg;
    logic [CW-1:0]               sp_next;
    logic [DATA_WIDTH-1:0]       tos_reg;
    logic [DATA_WIDTH-1:0]       tos_next;
    logic [DATA_WIDTH-1:0]       nos_reg;
    logic [DATA_WIDTH-1:0]       nos_next;
    logic [psc_pkg::STATUS_W-1:0] status_reg;
    logic [psc_pkg::STATUS_W-1:0] status_next;

    logic                        m_valid_reg;
    logic [psc_pkg::TOP_W-1:0]   out_top_reg;
    logic [psc_pkg::COUNT_W-1:0] out_count_reg;
    logic [psc_pkg::STATUS_W-1:0] out_status_reg;
    logic                        load_out;
    logic                        out_free;

    logic                        sp_ge2;
    logic                        sp_ge3;
    logic                        sp_full;

    logic                        au_start;
    psc_pkg::au_op_t             au_op;
    logic                        au_done;
    logic [DATA_WIDTH-1:0]       au_result;

    psc_arith #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (au_start),
        .op      (au_op),
        .a       (nos_reg),
        .b       (tos_reg),
        .done    (au_done),
        .result  (au_result)
    );

    assign sp_ge2   = (sp_reg >= CW'(2));
    assign sp_ge3   = (sp_reg >= CW'(3));
    assign sp_full  = (sp_reg >= CW'(STACK_DEPTH));
    assign out_free = !m_valid_reg || m_tready;
    assign rd_addr  = AW'(sp_reg - CW'(3));
    assign wr_addr  = AW'(sp_reg - CW'(2));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psc_pkg::BK_READY: begin
                if (q_head.valid) begin
                    state_next = psc_pkg::BK_RESP;
                    unique case (q_head.kind)
                        psc_pkg::OK_ADD, psc_pkg::OK_SUB: begin
                            if (sp_ge3) begin
                                state_next = psc_pkg::BK_FILL;
                            end
                        end
                        psc_pkg::OK_MUL: begin
                            if (sp_ge2) begin
                                state_next = psc_pkg::BK_WAIT;
                            end
                        end
                        psc_pkg::OK_DIV: begin
                            if (sp_ge2 && (tos_reg != '0)) begin
                                state_next = psc_pkg::BK_WAIT;
                            end
                        end
                        default: state_next = psc_pkg::BK_RESP;
                    endcase
                end
            end
            psc_pkg::BK_WAIT: begin
                if (au_done) begin
                    state_next = sp_ge3 ? psc_pkg::BK_FILL : psc_pkg::BK_RESP;
                end
            end
            psc_pkg::BK_FILL: state_next = psc_pkg::BK_RESP;
            psc_pkg::BK_RESP: begin
                if (out_free) begin
                    state_next = psc_pkg::BK_READY;
                end
            end
            default: state_next = psc_pkg::BK_READY;
        endcase
    end

    // Control strobes and datapath updates.
    always_comb begin
        q_pop       = 1'b0;
        au_start    = 1'b0;
        au_op       = psc_pkg::AU_MUL;
        mem_we      = 1'b0;
        load_out    = 1'b0;
        sp_next     = sp_reg;
        tos_next    = tos_reg;
        nos_next    = nos_reg;
        status_next = status_reg;
        unique case (state_reg)
            psc_pkg::BK_READY: begin
                if (q_head.valid) begin
                    q_pop       = 1'b1;
                    status_next = psc_pkg::ST_OK;
                    unique case (q_head.kind)
                        psc_pkg::OK_PUSH: begin
                            if (sp_full) begin
                                status_next = psc_pkg::ST_OVER;
                            end else begin
                                mem_we   = sp_ge2;
                                nos_next = tos_reg;
                                tos_next = q_value;
                                sp_next  = sp_reg + 1'b1;
                            end
                        end
                        psc_pkg::OK_ADD: begin
                            if (!sp_ge2) begin
                                status_next = psc_pkg::ST_UNDER;
                            end else begin
                                tos_next = nos_reg + tos_reg;
                                sp_next  = sp_reg - 1'b1;
                            end
                        end
                        psc_pkg::OK_SUB: begin
                            if (!sp_ge2) begin
                                status_next = psc_pkg::ST_UNDER;
                            end else begin
                                tos_next = nos_reg - tos_reg;
                                sp_next  = sp_reg - 1'b1;
                            end
                        end
                        psc_pkg::OK_MUL: begin
                            if (!sp_ge2) begin
                                status_next = psc_pkg::ST_UNDER;
                            end else begin
                                au_start = 1'b1;
                                au_op    = psc_pkg::AU_MUL;
                            end
                        end
                        psc_pkg::OK_DIV: begin
                            if (!sp_ge2) begin
                                status_next = psc_pkg::ST_UNDER;
                            end else if (tos_reg == '0) begin
                                status_next = psc_pkg::ST_DIVZ;
                            end else begin
                                au_start = 1'b1;
                                au_op    = psc_pkg::AU_DIV;
                            end
                        end
                        default: status_next = psc_pkg::ST_OK;
                    endcase
                end
            end
            psc_pkg::BK_WAIT: begin
                if (au_done) begin
                    tos_next = au_result;
                    sp_next  = sp_reg - 1'b1;
                end
            end
            psc_pkg::BK_FILL: nos_next = rd_data_reg;
            psc_pkg::BK_RESP: load_out = out_free;
            default: load_out = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psc_pkg::BK_READY;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg    <= tos_next;
        nos_reg    <= nos_next;
        status_reg <= status_next;
        if (load_out) begin
            out_top_reg    <= (sp_reg == '0) ? '0 : psc_pkg::TOP_W'(tos_reg);
            out_count_reg  <= psc_pkg::COUNT_W'(sp_reg);
            out_status_reg <= status_reg;
        end
    end

    // The top memory entry, third from the top of the stack, is read every cycle, ready for a refill after a pop.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= nos_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid    = m_valid_reg;
    assign top_value   = out_top_reg;
    assign stack_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

[hw/rtl/postfix_stack_calculator_unit.sv]
`timescale 1ns / 1ps
// Postfix stack calculator: evaluates postfix tokens on an operand stack.
// Uses a request on the s_ channel, carrying one token: cmd in s_tdata[2:0], operand in
// s_tdata[34:3]. Each token gives exactly one result request on the m_ channel with
// top_value in m_tdata[31:0], stack_count in m_tdata[36:32] and status in m_tdata[38:37].
// Status is ok, underflow, overflow or divide by zero; the faulty cases leave the stack as is.
// The front end queues up to two tokens, so tokens are taken while the back end works
// or while a result waits on the m_ channel.
// Push, add, subtract and unknown commands pass through the back end's ready and response
// states, and an add or subtract also through its fill state when it has to refill the
// second entry from the stack memory. Multiply and divide run on a shared bit-serial unit,
// one bit per cycle; the back end waits for it in its wait state, refills when needed, then
// responds. The result is registered, so m_tvalid rises after the back end's response state.
// Reset empties the stack and the token queue and drops any pending result. While m_tready
// is low the result is held, the back end stops after its next token, and the queue fills
// until s_tready falls.
// Depends on psc_pkg, psc_front, psc_arith and psc_back.
module postfix_stack_calculator_unit #(
    parameter int STACK_DEPTH = psc_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = psc_pkg::DEF_DATA_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cmd [2:0], operand [34:3], zero [39:35]
    input  logic [psc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // top_value [31:0], stack_count [36:32], status [38:37], zero [39]
    output logic [psc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    psc_pkg::q_head_t             q_head;
    logic [DATA_WIDTH-1:0]        q_value;
    logic                         q_pop;
    logic [psc_pkg::TOP_W-1:0]    out_top;
    logic [psc_pkg::COUNT_W-1:0]  out_count;
    logic [psc_pkg::STATUS_W-1:0] out_status;

    psc_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (s_tdata[2:0]),
        .operand  (s_tdata[34:3]),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .q_value  (q_value)
    );

    psc_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_value     (q_value),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .top_value   (out_top),
        .stack_count (out_count),
        .status      (out_status)
    );

    assign m_tdata = {1'b0, out_status, out_count, out_top};

    // An underflow can only be reported with fewer than two entries held.
    a_under_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_status == psc_pkg::ST_UNDER)) |-> (out_count < 5'd2))
        else $error("underflow reported with two or more entries");

    // An overflow is only reported on a full stack.
    a_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_status == psc_pkg::ST_OVER))
            |-> (out_count == psc_pkg::COUNT_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    // A divide by zero leaves the zero divisor on top.
    a_divz_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_status == psc_pkg::ST_DIVZ)) |-> (out_top == '0))
        else $error("divide by zero reported with a non-zero top");

    // The input side only stalls when the queue holds work for the back end.
    a_stall_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_head.valid)
        else $error("input stalled with an empty token queue");

endmodule
